[rtl/core/mlp_pkg.sv]
// shared constants, types and functions for the mlp inference unit
package mlp_pkg;

    localparam int MaxLayers = 3;
    localparam int MaxWidth  = 16;
    localparam int DataBits  = 16;
    localparam int FracBits  = 12;
    localparam int AccBits   = 40;
    localparam int IdxBits   = 4;
    localparam int LayBits   = 2;
    localparam int WAddrBits = 10;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;

    localparam logic [2:0] CFG_LAYERS = 3'd0;
    localparam logic [2:0] CFG_WIN    = 3'd1;
    localparam logic [2:0] CFG_WONE   = 3'd2;
    localparam logic [2:0] CFG_WTWO   = 3'd3;
    localparam logic [2:0] CFG_WTHREE = 3'd4;

    typedef logic signed [DataBits-1:0] data_t;
    typedef logic signed [AccBits-1:0]  acc_t;

    // control from sequencer to the cell row
    typedef struct packed {
        logic             clear;
        logic             mac;
        logic             load;
        logic [IdxBits-1:0] sel;
    } cell_ctl_t;

    function automatic logic [16:0] sig_entry(input logic [4:0] k);
        logic [16:0] r;
        begin
            unique case (k)
                5'd0:  r = 17'd22;
                5'd1:  r = 17'd60;
                5'd2:  r = 17'd162;
                5'd3:  r = 17'd439;
                5'd4:  r = 17'd1179;
                5'd5:  r = 17'd3108;
                5'd6:  r = 17'd7812;
                5'd7:  r = 17'd17625;
                5'd8:  r = 17'd32768;
                5'd9:  r = 17'd47911;
                5'd10: r = 17'd57724;
                5'd11: r = 17'd62428;
                5'd12: r = 17'd64357;
                5'd13: r = 17'd65097;
                5'd14: r = 17'd65374;
                5'd15: r = 17'd65476;
                default: r = 17'd65514;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] eff_width(input logic [4:0] w);
        begin
            if (w == 5'd0) return 5'd1;
            if (w > 5'(MaxWidth)) return 5'(MaxWidth);
            return w;
        end
    endfunction

endpackage

[rtl/core/mlp_cell.sv]
// one neuron accumulator cell, shifts its result along the row when loading
module mlp_cell (
    input  logic                 aclk,
    input  mlp_pkg::cell_ctl_t   ctl,
    input  mlp_pkg::data_t       act,
    input  mlp_pkg::data_t       weight,
    input  mlp_pkg::data_t       bias,
    input  logic                 bias_en,
    input  mlp_pkg::acc_t        shift_in,
    output mlp_pkg::acc_t        acc
);
    import mlp_pkg::*;

    acc_t acc_reg, acc_next;
    logic signed [2*DataBits-1:0] prod;

    assign prod = act * weight;

    always_comb begin
        acc_next = acc_reg;
        priority if (ctl.clear) begin
            acc_next = bias_en ? (AccBits'(bias) <<< FracBits) : '0;
        end else if (ctl.load) begin
            acc_next = shift_in;
        end else if (ctl.mac) begin
            acc_next = acc_reg + AccBits'(prod);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule

[rtl/core/mlp_divider.sv]
// restoring divider for the probability normalization, one bit per cycle
module mlp_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] num,
    input  logic [20:0] den,
    output logic        done,
    output logic [15:0] quo
);
    import mlp_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [33:0] dvd_reg, dvd_next;
    logic [33:0] q_reg, q_next;
    logic [20:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[32:0], dvd_reg[33]};
        if (start) begin
            rem_next  = '0;
            dvd_next  = {1'b0, num, 16'd0};
            q_next    = '0;
            den_next  = den;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[32:0], 1'b0};
            if (trial >= 34'(den_reg)) begin
                rem_next = trial - 34'(den_reg);
                q_next   = {q_reg[32:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = (q_reg > 34'd65535) ? 16'hFFFF : q_reg[15:0];
endmodule

[rtl/core/mlp_forward_inference_unit.sv]
// top level: stores, sequencer, cell row, sigmoid and normalization
// loads and input elements: one item per cycle while idle, no result except on last
// inference: per layer a clear, one mac per input of the layer, then a drain or sigmoid pass
//   over the whole row; then per output a start, a 34-step serial divide, done and output
// intake stalls until the last result is registered; m_ready stalls hold the output
// reset (aresetn low, synchronous) clears control and config; stores are undefined
module mlp_forward_inference_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [1:0]  s_layer,
    input  logic [3:0]  s_row,
    input  logic [3:0]  s_col,
    input  logic signed [15:0] s_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_index,
    output logic [15:0] m_probability,
    output logic        m_last_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import mlp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SIG   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [1:0] lcount_reg;
    logic [4:0] win_reg, wone_reg, wtwo_reg, wthree_reg;

    // one word per layer and source row, one lane per destination neuron
    logic [MaxWidth*DataBits-1:0] wmem [MaxLayers*MaxWidth];
    logic [MaxWidth*DataBits-1:0] bmem [MaxLayers];
    logic [MaxWidth*DataBits-1:0] wword_reg;
    data_t amem [MaxWidth];
    data_t relay [MaxWidth];
    logic [16:0] smem [MaxWidth];

    logic [2:0] st_reg, st_next;
    logic [1:0] lay_reg, lay_next;
    logic [4:0] i_reg, i_next;
    logic [4:0] j_reg, j_next;
    logic [20:0] sum_reg, sum_next;
    logic [3:0] oidx_reg;
    logic [15:0] oprob_reg;
    logic oval_reg, olast_reg;

    logic [1:0] nl;
    logic [4:0] nin, nou, nfin;
    logic s_fire;
    cell_ctl_t ctl;
    acc_t acc [MaxWidth];
    data_t wrow [MaxWidth];
    data_t brow [MaxWidth];
    data_t act;
    logic  div_start, div_done;
    logic [15:0] div_q;
    logic [16:0] snum;

    always_comb begin
        nl = (lcount_reg == 2'd0) ? 2'd1 : lcount_reg;
        nin = eff_width(win_reg);
        nou = eff_width(wone_reg);
        unique case (lay_reg)
            2'd0: begin nin = eff_width(win_reg);  nou = eff_width(wone_reg);   end
            2'd1: begin nin = eff_width(wone_reg); nou = eff_width(wtwo_reg);   end
            default: begin nin = eff_width(wtwo_reg); nou = eff_width(wthree_reg); end
        endcase
        unique case (nl)
            2'd1: nfin = eff_width(wone_reg);
            2'd2: nfin = eff_width(wtwo_reg);
            default: nfin = eff_width(wthree_reg);
        endcase
    end

    assign s_ready   = (st_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcount_reg <= 2'd1;
            win_reg    <= 5'd16;
            wone_reg   <= 5'd16;
            wtwo_reg   <= 5'd16;
            wthree_reg <= 5'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LAYERS: lcount_reg <= cfg_data[1:0];
                CFG_WIN:    win_reg    <= cfg_data;
                CFG_WONE:   wone_reg   <= cfg_data;
                CFG_WTWO:   wtwo_reg   <= cfg_data;
                CFG_WTHREE: wthree_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // weight and bias stores, one row of weights read per cycle
    always_ff @(posedge aclk) begin
        if (s_fire && s_operation == OP_WEIGHT && s_layer != 2'd3) begin
            wmem[{s_layer, s_row}][s_col*DataBits +: DataBits] <= s_value;
        end
        if (s_fire && s_operation == OP_BIAS && s_layer != 2'd3) begin
            bmem[s_layer][s_col*DataBits +: DataBits] <= s_value;
        end
        if (s_fire && s_operation == OP_INPUT) begin
            amem[s_col] <= s_value;
        end
        // row addressed by the next index and registered for the mac that uses it in the next cycle
        wword_reg <= wmem[{lay_next, i_next[3:0]}];
    end

    // layer zero reads the input elements, later layers the parked hidden values
    always_comb begin
        if (lay_reg == 2'd0) begin
            act = amem[i_reg[3:0]];
        end else begin
            act = relay[i_reg[3:0]];
        end
    end

    for (genvar c = 0; c < MaxWidth; c++) begin : g_row
        assign wrow[c] = wword_reg[c*DataBits +: DataBits];
        assign brow[c] = bmem[lay_reg][c*DataBits +: DataBits];
        mlp_cell u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .act     (act),
            .weight  (wrow[c]),
            .bias    (brow[c]),
            .bias_en (5'(c) < nou),
            .shift_in(c == MaxWidth-1 ? acc[0] : acc[(c+1)%MaxWidth]),
            .acc     (acc[c])
        );
    end

    // post process of the head cell: round, saturate, relu on hidden layers
    logic signed [AccBits-1:0] rnd;
    data_t post;
    logic hidden;
    always_comb begin
        rnd = (acc[0] + AccBits'(1 << (FracBits-1))) >>> FracBits;
        if (rnd > AccBits'(32767)) post = 16'sh7FFF;
        else if (rnd < -AccBits'(32768)) post = 16'sh8000;
        else post = rnd[DataBits-1:0];
        hidden = (2'(lay_reg + 2'd1) < nl);
        if (hidden && post < 0) post = '0;
    end

    // sigmoid of the head value; inputs are clipped to +/-8, the ends of the table range
    logic signed [17:0] xs;
    logic [16:0] u;
    logic [16:0] s0, s1, sig;
    always_comb begin
        xs = 18'(post);
        if (xs > 18'sd32768) xs = 18'sd32768;
        if (xs < -18'sd32768) xs = -18'sd32768;
        u = 17'(xs + 18'sd32768);
        s0 = sig_entry(u[16:12]);
        s1 = sig_entry(5'(u[16:12] + 5'd1));
        if (u[16]) sig = sig_entry(5'd16);
        else sig = s0 + 17'(((s1 - s0) * 29'(u[11:0])) >> FracBits);
    end

    // sequencer control for the cell row; drain and sigmoid rotate the row
    always_comb begin
        ctl = '0;
        ctl.sel = i_reg[3:0];
        unique case (st_reg)
            ST_CLEAR: ctl.clear = 1'b1;
            ST_MAC:   ctl.mac = 1'b1;
            ST_DRAIN: ctl.load = 1'b1;
            ST_SIG:   ctl.load = 1'b1;
            default: ;
        endcase
    end

    // hidden results are parked in a small register file during the next layer
    always_ff @(posedge aclk) begin
        if (st_reg == ST_DRAIN) relay[j_reg[3:0]] <= post;
        if (st_reg == ST_SIG) smem[j_reg[3:0]] <= sig;
    end

    assign snum = smem[j_reg[3:0]];
    assign div_start = (st_reg == ST_DIV) && (i_reg == 5'd0);

    mlp_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (snum),
        .den    (sum_reg),
        .done   (div_done),
        .quo    (div_q)
    );

    always_comb begin
        st_next  = st_reg;
        lay_next = lay_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        sum_next = sum_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_fire && s_operation == OP_INPUT && s_last) begin
                    st_next = ST_CLEAR;
                    lay_next = 2'd0;
                end
            end
            ST_CLEAR: begin
                st_next = ST_MAC;
                i_next = '0;
            end
            ST_MAC: begin
                i_next = i_reg + 5'd1;
                if (i_reg + 5'd1 == nin) begin
                    j_next = '0;
                    sum_next = '0;
                    st_next = (2'(lay_reg + 2'd1) == nl) ? ST_SIG : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                j_next = j_reg + 5'd1;
                if (j_reg + 5'd1 == MaxWidth) begin
                    lay_next = lay_reg + 2'd1;
                    st_next = ST_CLEAR;
                end
            end
            ST_SIG: begin
                j_next = j_reg + 5'd1;
                if (j_reg < nfin) sum_next = sum_reg + 21'(sig);
                if (j_reg + 5'd1 == MaxWidth) begin
                    j_next = '0;
                    i_next = '0;
                    st_next = ST_DIV;
                end
            end
            ST_DIV: begin
                i_next = 5'd1;
                if (div_done) st_next = ST_OUT;
            end
            ST_OUT: begin
                if (!oval_reg || m_ready) begin
                    j_next = j_reg + 5'd1;
                    i_next = '0;
                    st_next = (j_reg + 5'd1 == nfin) ? ST_IDLE : ST_DIV;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            lay_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            oval_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            lay_reg <= lay_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            if (m_valid && m_ready) oval_reg <= 1'b0;
            if (st_reg == ST_OUT && (!oval_reg || m_ready)) oval_reg <= 1'b1;
        end
        sum_reg  <= sum_next;
        if (st_reg == ST_OUT && (!oval_reg || m_ready)) begin
            oidx_reg  <= j_reg[3:0];
            oprob_reg <= div_q;
            olast_reg <= (j_reg + 5'd1 == nfin);
        end
    end

    assign m_valid       = oval_reg;
    assign m_index       = oidx_reg;
    assign m_probability = oprob_reg;
    assign m_last_res    = olast_reg;
endmodule
